// ----- rtl/core/refb_pkg.sv -----
// ----------------------------------------------------------------------------
// refb_pkg: shared types and constants of the trimmed-mean 3x3 RGB filter
// Pixel and line store entry types, pipeline beat bundles, register indexes
// and the fixed arithmetic constants of the divide by seven.
// ----------------------------------------------------------------------------
`default_nettype none

package refb_pkg;

    // Line store depth (widest supported row)
    localparam int MAX_WIDTH   = 1024;
    localparam int COL_W       = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int WCNT_W      = $clog2(MAX_WIDTH + 1);

    // Configuration registers
    localparam int FW_W        = 11;
    localparam int FH_W        = 16;
    localparam int ROW_W       = FH_W + 1;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;
    localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 16'd480;
    localparam int MIN_DIM     = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // Pixel arithmetic
    localparam int CHAN_W      = 8;
    localparam int CHAN_MAX    = 255;
    localparam int LUMA_W      = 10;
    localparam int SUM_W       = 12;
    localparam int WIN_SIZE    = 9;
    localparam int WIN_CENTER  = 4;
    localparam int WIN_IDX_W   = 4;

    // Divide by seven: floor(t * RECIP7 / 2^RECIP_SHIFT) is exact for t < 5461
    localparam int RECIP7      = 4682;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 15;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    // Output queue and result credit
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam int INFLIGHT_W  = 3;

    // Channel 2 is red, 1 is green, 0 is blue
    typedef logic [2:0][CHAN_W-1:0] pixel_t;

    typedef struct packed {
        pixel_t upper;
        pixel_t lower;
    } line_entry_t;

    typedef struct packed {
        logic result;
        logic interior;
        logic frame_end;
    } meta_t;

    typedef struct packed {
        logic             act;
        meta_t            meta;
        logic [COL_W-1:0] col;
        pixel_t           px;
    } front_t;

    typedef struct packed {
        pixel_t px;
        logic   frame_end;
    } out_beat_t;

endpackage

`default_nettype wire

// ----- rtl/core/refb_stream_ifs.sv -----
// ----------------------------------------------------------------------------
// refb_stream_ifs: pixel stream channels of the trimmed-mean filter
// Input channel carries an op code and one RGB pixel, output channel one
// filtered pixel and a frame end mark. A beat moves when valid and ready meet.
// ----------------------------------------------------------------------------
`default_nettype none

interface refb_pixel_in_if
    import refb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              op;
    logic [CHAN_W-1:0] in_red;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_blue;

    modport source (output valid, op, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, op, in_red, in_green, in_blue, output ready);
endinterface

interface refb_pixel_out_if
    import refb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic              frame_end;

    modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/refb_ctrl.sv -----
// ----------------------------------------------------------------------------
// refb_ctrl: raster position tracking and line store addressing
// Holds the frame size registers and the column and row of the next input,
// decides per beat whether it drains, yields a result, lies inside the
// image and ends the frame, and issues the line store read.
// ----------------------------------------------------------------------------
`default_nettype none

module refb_ctrl
    import refb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   accept,
    input  logic                   op,
    input  pixel_t                 in_px,
    output logic                   rd_en,
    output logic [COL_W-1:0]       rd_addr,
    output front_t                 front
);

    logic [FW_W-1:0]   frame_width_reg;
    logic [FH_W-1:0]   frame_height_reg;
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;

    logic              front_act_reg;
    meta_t             front_meta_reg;
    logic [COL_W-1:0]  front_col_reg;
    pixel_t            front_px_reg;

    logic [WCNT_W-1:0] w_eff;
    logic [FH_W-1:0]   h_eff;
    logic [ROW_W-1:0]  h_ext;
    logic [WCNT_W-1:0] col_ext;
    logic [WCNT_W-1:0] c_ext;
    logic [WCNT_W-1:0] c_inc;
    logic [COL_W-1:0]  c;
    logic [ROW_W-1:0]  row_a;
    logic [ROW_W-1:0]  orow;
    logic [WCNT_W-1:0] ocol;
    logic              draining;
    logic              act;
    logic              result;
    logic              interior;
    logic              frame_end;
    pixel_t            px;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_W-1:0];
            endcase
        end
    end

    // Clamp frame size to the supported range
    always_comb
    begin
        if (32'(frame_width_reg) < MIN_DIM)
            w_eff = WCNT_W'(MIN_DIM);
        else if (32'(frame_width_reg) > MAX_WIDTH)
            w_eff = WCNT_W'(MAX_WIDTH);
        else
            w_eff = WCNT_W'(frame_width_reg);

        if (32'(frame_height_reg) < MIN_DIM)
            h_eff = FH_W'(MIN_DIM);
        else
            h_eff = frame_height_reg;
        h_ext = ROW_W'(h_eff);
    end

    // Locate the beat in the raster and decide what it produces
    always_comb
    begin
        draining = (in_row_reg >= h_ext);
        act      = accept && (draining || !op);
        px       = draining ? '0 : in_px;

        // wrap a column left beyond a shrunken width
        col_ext = WCNT_W'(in_col_reg);
        if (col_ext >= w_eff)
        begin
            c     = '0;
            row_a = in_row_reg + ROW_W'(1);
        end
        else
        begin
            c     = in_col_reg;
            row_a = in_row_reg;
        end
        c_ext = WCNT_W'(c);

        if (c == '0)
        begin
            orow = row_a - ROW_W'(2);
            ocol = w_eff - WCNT_W'(1);
        end
        else
        begin
            orow = row_a - ROW_W'(1);
            ocol = c_ext - WCNT_W'(1);
        end

        result    = act && ((row_a >= ROW_W'(2)) || (row_a == ROW_W'(1) && c != '0));
        interior  = (orow >= ROW_W'(1)) && (orow <= h_ext - ROW_W'(2))
                 && (ocol >= WCNT_W'(1)) && (ocol <= w_eff - WCNT_W'(2));
        frame_end = result && (orow >= h_ext - ROW_W'(1)) && (ocol == w_eff - WCNT_W'(1));

        // advance to the next position
        c_inc = c_ext + WCNT_W'(1);
        if (c_inc >= w_eff)
        begin
            in_col_next = '0;
            in_row_next = row_a + ROW_W'(1);
        end
        else
        begin
            in_col_next = c_inc[COL_W-1:0];
            in_row_next = row_a;
        end
        if (frame_end)
        begin
            in_col_next = '0;
            in_row_next = '0;
        end
    end

    // Hold raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
        end
        else if (act)
        begin
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
        end
    end

    // Front stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_act_reg  <= 1'b0;
            front_meta_reg <= '0;
        end
        else
        begin
            front_act_reg  <= act;
            front_meta_reg <= '{result: result, interior: interior, frame_end: frame_end};
        end
    end

    // Front stage payload
    always_ff @(posedge clk)
    begin
        front_col_reg <= c;
        front_px_reg  <= px;
    end

    assign rd_en   = act;
    assign rd_addr = c;
    assign front   = '{act: front_act_reg, meta: front_meta_reg,
                       col: front_col_reg, px: front_px_reg};

endmodule

`default_nettype wire

// ----- rtl/core/refb_line_mem.sv -----
// ----------------------------------------------------------------------------
// refb_line_mem: two-row line store
// One entry per column holds the pixel two rows up and the pixel one row up.
// Simple dual port: one write and one registered read per cycle; a read of
// the entry written at the same edge returns the new data.
// ----------------------------------------------------------------------------
`default_nettype none

module refb_line_mem
    import refb_pkg::*;
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [COL_W-1:0] rd_addr,
    output line_entry_t      rd_data,
    input  logic             wr_en,
    input  logic [COL_W-1:0] wr_addr,
    input  line_entry_t      wr_data
);

    line_entry_t mem [MAX_WIDTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Read port, registered; forward a write to the same column
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
                rd_data <= wr_data;
            else
                rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/refb_window.sv -----
// ----------------------------------------------------------------------------
// refb_window: line store write-back, 3x3 window and trimmed mean datapath
// Rotates the line store entry, shifts the window, then over three stages
// sums the channels, finds the brightest and darkest pixels, removes them,
// divides by seven and clamps. Border positions take the window center.
// ----------------------------------------------------------------------------
`default_nettype none

module refb_window
    import refb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  front_t                front,
    input  line_entry_t           rd_data,
    output logic                  wr_en,
    output logic [COL_W-1:0]      wr_addr,
    output line_entry_t           wr_data,
    output logic                  push_valid,
    output out_beat_t             push_beat,
    output logic [INFLIGHT_W-1:0] pending
);

    pixel_t                  win_reg [WIN_SIZE];
    meta_t                   sh_meta_reg;

    meta_t                   st_meta_reg;
    pixel_t                  st_win_reg [WIN_SIZE];
    logic [LUMA_W-1:0]       st_luma_reg [WIN_SIZE];
    logic [2:0][SUM_W-1:0]   st_sum_reg;

    meta_t                   sel_meta_reg;
    logic [2:0][SUM_W-1:0]   sel_sum_reg;
    pixel_t                  sel_hi_reg;
    pixel_t                  sel_lo_reg;
    pixel_t                  sel_center_reg;

    logic [LUMA_W-1:0]       luma [WIN_SIZE];
    logic [2:0][SUM_W-1:0]   sum;
    logic [WIN_IDX_W-1:0]    hi_idx, lo_idx;
    logic [LUMA_W-1:0]       hi_val, lo_val;
    logic [2:0][SUM_W-1:0]   trim;
    logic [2:0][PROD_W-1:0]  prod;
    logic [2:0][QUOT_W-1:0]  quot;
    pixel_t                  mean_px;

    // Rotate the line store entry: lower row moves up, new pixel enters
    assign wr_en   = front.act;
    assign wr_addr = front.col;
    assign wr_data = '{upper: rd_data.lower, lower: front.px};

    // Shift the window one column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_SIZE; i++)
                win_reg[i] <= '0;
        end
        else if (front.act)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r*3]     <= win_reg[r*3 + 1];
                win_reg[r*3 + 1] <= win_reg[r*3 + 2];
            end
            win_reg[2] <= rd_data.upper;
            win_reg[5] <= rd_data.lower;
            win_reg[8] <= front.px;
        end
    end

    // Stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sh_meta_reg  <= '0;
            st_meta_reg  <= '0;
            sel_meta_reg <= '0;
        end
        else
        begin
            sh_meta_reg  <= front.meta;
            st_meta_reg  <= sh_meta_reg;
            sel_meta_reg <= st_meta_reg;
        end
    end

    // Brightness per pixel and channel sums over the window
    always_comb
    begin
        sum = '0;
        for (int i = 0; i < WIN_SIZE; i++)
        begin
            luma[i] = LUMA_W'(win_reg[i][2]) + LUMA_W'(win_reg[i][1])
                    + LUMA_W'(win_reg[i][0]);
            for (int k = 0; k < 3; k++)
                sum[k] = sum[k] + SUM_W'(win_reg[i][k]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WIN_SIZE; i++)
        begin
            st_win_reg[i]  <= win_reg[i];
            st_luma_reg[i] <= luma[i];
        end
        st_sum_reg <= sum;
    end

    // Pick the first brightest and the last darkest pixel
    always_comb
    begin
        hi_idx = '0;
        lo_idx = '0;
        hi_val = st_luma_reg[0];
        lo_val = st_luma_reg[0];
        for (int i = 1; i < WIN_SIZE; i++)
        begin
            if (st_luma_reg[i] > hi_val)
            begin
                hi_val = st_luma_reg[i];
                hi_idx = WIN_IDX_W'(i);
            end
            if (st_luma_reg[i] <= lo_val)
            begin
                lo_val = st_luma_reg[i];
                lo_idx = WIN_IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sel_sum_reg    <= st_sum_reg;
        sel_hi_reg     <= st_win_reg[hi_idx];
        sel_lo_reg     <= st_win_reg[lo_idx];
        sel_center_reg <= st_win_reg[WIN_CENTER];
    end

    // Drop the extremes, divide by seven through the reciprocal, clamp
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            trim[k] = sel_sum_reg[k] - SUM_W'(sel_hi_reg[k]) - SUM_W'(sel_lo_reg[k]);
            prod[k] = PROD_W'(trim[k]) * PROD_W'(RECIP7);
            quot[k] = prod[k][PROD_W-1:RECIP_SHIFT];
            if (quot[k] > QUOT_W'(CHAN_MAX))
                mean_px[k] = CHAN_W'(CHAN_MAX);
            else
                mean_px[k] = quot[k][CHAN_W-1:0];
        end
    end

    assign push_valid = sel_meta_reg.result;
    assign push_beat  = '{px: sel_meta_reg.interior ? mean_px : sel_center_reg,
                          frame_end: sel_meta_reg.frame_end};

    assign pending = INFLIGHT_W'(sh_meta_reg.result) + INFLIGHT_W'(st_meta_reg.result)
                   + INFLIGHT_W'(sel_meta_reg.result);

endmodule

`default_nettype wire

// ----- rtl/core/refb_out_fifo.sv -----
// ----------------------------------------------------------------------------
// refb_out_fifo: result queue in front of the output channel
// Absorbs results while the receiver stalls. Its level feeds the input
// credit check, so a push never finds it full.
// ----------------------------------------------------------------------------
`default_nettype none

module refb_out_fifo
    import refb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    input  out_beat_t             push_beat,
    refb_pixel_out_if.source      pixel_out,
    output logic [FIFO_CNT_W-1:0] count
);

    out_beat_t               fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic                    pop;
    out_beat_t               head;

    assign pop = pixel_out.valid && pixel_out.ready;

    // Store pushed beats
    always_ff @(posedge clk)
    begin
        if (push_valid)
            fifo_mem[wr_ptr_reg] <= push_beat;
    end

    // Advance pointers and level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_valid)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            case ({push_valid, pop})
                2'b10:   count_reg <= count_reg + FIFO_CNT_W'(1);
                2'b01:   count_reg <= count_reg - FIFO_CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    // Present the head beat
    assign head                = fifo_mem[rd_ptr_reg];
    assign pixel_out.valid     = (count_reg != '0);
    assign pixel_out.out_red   = head.px[2];
    assign pixel_out.out_green = head.px[1];
    assign pixel_out.out_blue  = head.px[0];
    assign pixel_out.frame_end = head.frame_end;
    assign count               = count_reg;

endmodule

`default_nettype wire

// ----- rtl/core/rgb_extremum_filtered_blur_3x3.sv -----
// ----------------------------------------------------------------------------
// rgb_extremum_filtered_blur_3x3: trimmed-mean 3x3 RGB filter, top level
// Raster pixel stream in, filtered pixel stream out, width+1 positions late.
//
// pixel_in carries op (0 = pixel, 1 = flush) and one RGB pixel per beat.
// pixel_out carries the filtered pixel of an earlier position and frame_end,
// set on the last pixel of the frame. After the last pixel of a frame,
// width+1 flush beats (or pixel beats, whose data is dropped) drain the tail;
// a flush while the frame is still open is taken and has no effect.
// The frame size registers are written through cfg_write / cfg_index /
// cfg_data while the stream is idle.
// Throughput: one beat per cycle while pixel_in.ready is high, set by the
// single line store read and write-back per beat and the fully pipelined
// window datapath. A result on pixel_out, from the beat that completes its
// window, passes the line store read, window shift, sum, select and divide.
// Reset clears position counters, window and queue; the line store is not
// cleared and is not needed to be, so pixel_in is ready right after reset.
// When the receiver stalls, up to 8 results are held; pixel_in.ready drops
// once queued plus in-flight results reach that depth.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_extremum_filtered_blur_3x3
    import refb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    refb_pixel_in_if.sink          pixel_in,
    refb_pixel_out_if.source       pixel_out
);

    logic                    accept;
    pixel_t                  in_px;
    logic                    rd_en;
    logic [COL_W-1:0]        rd_addr;
    line_entry_t             rd_data;
    logic                    wr_en;
    logic [COL_W-1:0]        wr_addr;
    line_entry_t             wr_data;
    front_t                  front;
    logic                    push_valid;
    out_beat_t               push_beat;
    logic [INFLIGHT_W-1:0]   pending;
    logic [INFLIGHT_W-1:0]   inflight;
    logic [FIFO_CNT_W-1:0]   fifo_count;
    logic [FIFO_CNT_W:0]     credit_used;

    // Take a beat only when the queue has room for every result in flight
    assign inflight       = pending + INFLIGHT_W'(front.meta.result);
    assign credit_used    = (FIFO_CNT_W+1)'(fifo_count) + (FIFO_CNT_W+1)'(inflight);
    assign pixel_in.ready = (credit_used < (FIFO_CNT_W+1)'(FIFO_DEPTH));
    assign accept         = pixel_in.valid && pixel_in.ready;
    assign in_px          = {pixel_in.in_red, pixel_in.in_green, pixel_in.in_blue};

    refb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .op        (pixel_in.op),
        .in_px     (in_px),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .front     (front)
    );

    refb_line_mem u_line_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    refb_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .front      (front),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .push_valid (push_valid),
        .push_beat  (push_beat),
        .pending    (pending)
    );

    refb_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_beat  (push_beat),
        .pixel_out  (pixel_out),
        .count      (fifo_count)
    );

`ifndef SYNTHESIS
    // A result never arrives at a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> (fifo_count < FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("result pushed into a full output queue");

    // Queued plus in-flight results stay within the queue depth
    assert property (@(posedge clk) disable iff (!rst_n)
        credit_used <= (FIFO_CNT_W+1)'(FIFO_DEPTH))
        else $error("result credit exceeded");

    // Every accepted pixel beat rotates the line store on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_in.valid && pixel_in.ready && !pixel_in.op) |=> front.act)
        else $error("accepted pixel did not reach the line store");
`endif

endmodule

`default_nettype wire

// ----- dv/refb_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// refb_tb_pkg: beat codes of the trimmed-mean filter bench
// Operation codes of a pixel_in beat, shared by the stimulus and the
// scoreboard.
// ----------------------------------------------------------------------------

package refb_tb_pkg;

    typedef enum logic {
        BEAT_PIXEL = 1'b0,
        BEAT_FLUSH = 1'b1
    } beat_op_t;

endpackage

// ----- dv/refb_filter_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// refb_filter_checker: scoreboard of the trimmed-mean 3x3 RGB filter
// Mirrors register writes and accepted pixel_in beats into its own raster
// model (line stores, window, position counters), queues the expected
// pixel_out beats and compares every accepted output beat field by field.
// ----------------------------------------------------------------------------

module refb_filter_checker
    import refb_pkg::*;
    import refb_tb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    refb_pixel_in_if               pixel_in,
    refb_pixel_out_if              pixel_out,
    output int                     mismatches,
    output int                     pending,
    output int                     frames_done,
    output int                     results_checked,
    output int                     interior_results,
    output int                     flushes_dropped
);

    localparam int TRIM_DIVISOR = 7;

    logic [FW_W-1:0] cfg_width;
    logic [FH_W-1:0] cfg_height;
    pixel_t          upper_row [MAX_WIDTH];
    pixel_t          lower_row [MAX_WIDTH];
    pixel_t          win [3][3];
    int              next_col;
    int              next_row;
    out_beat_t       filtered_q [$];

    function automatic int rgb_total(pixel_t px);
        return int'(px[2]) + int'(px[1]) + int'(px[0]);
    endfunction

    // Sum the window, drop the first brightest and the last darkest pixel
    function automatic pixel_t trimmed_mean();
        int     sum [3];
        int     hi_idx;
        int     lo_idx;
        int     hi_val;
        int     lo_val;
        int     v;
        int     t;
        int     i;
        int     k;
        pixel_t px;
        pixel_t res;
        sum = '{0, 0, 0};
        hi_idx = 0;
        lo_idx = 0;
        hi_val = 0;
        lo_val = 0;
        for (i = 0; i < WIN_SIZE; i++)
        begin
            px = win[i / 3][i % 3];
            v = rgb_total(px);
            for (k = 0; k < 3; k++)
            begin
                sum[k] += int'(px[k]);
            end
            if (i == 0)
            begin
                hi_val = v;
                lo_val = v;
            end
            else
            begin
                if (v > hi_val)
                begin
                    hi_val = v;
                    hi_idx = i;
                end
                if (v <= lo_val)
                begin
                    lo_val = v;
                    lo_idx = i;
                end
            end
        end
        for (k = 0; k < 3; k++)
        begin
            t = (sum[k] - int'(win[hi_idx / 3][hi_idx % 3][k])
                        - int'(win[lo_idx / 3][lo_idx % 3][k])) / TRIM_DIVISOR;
            if (t > CHAN_MAX)
                t = CHAN_MAX;
            res[k] = CHAN_W'(t);
        end
        return res;
    endfunction

    // Advance the raster model by one beat; queue the output it releases
    task automatic predict_filtered(input logic op, input pixel_t px_in);
        int        w;
        int        h;
        int        c;
        int        r;
        int        orow;
        int        ocol;
        logic      draining;
        logic      emit;
        pixel_t    px;
        pixel_t    up;
        pixel_t    lo;
        out_beat_t beat;
        w = (cfg_width < MIN_DIM) ? MIN_DIM :
            (cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width);
        h = (cfg_height < MIN_DIM) ? MIN_DIM : int'(cfg_height);

        // a flush inside an open frame is taken and has no effect
        draining = (next_row >= h);
        if (!draining && op == BEAT_FLUSH)
        begin
            flushes_dropped++;
            return;
        end
        px = draining ? '0 : px_in;

        // restart the row if the width shrank under the column
        if (next_col >= w)
        begin
            next_col = 0;
            next_row++;
        end
        c = next_col;

        // rotate line stores and shift the window left
        up = upper_row[c];
        lo = lower_row[c];
        upper_row[c] = lo;
        lower_row[c] = px;
        for (r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = up;
        win[1][2] = lo;
        win[2][2] = px;

        emit = (next_row >= 2) || (next_row == 1 && c >= 1);
        if (c == 0)
        begin
            orow = next_row - 2;
            ocol = w - 1;
        end
        else
        begin
            orow = next_row - 1;
            ocol = c - 1;
        end
        next_col = c + 1;
        if (next_col >= w)
        begin
            next_col = 0;
            next_row++;
        end
        if (!emit)
            return;

        // filter interior positions, pass the border through
        if (orow >= 1 && orow <= h - 2 && ocol >= 1 && ocol <= w - 2)
        begin
            beat.px = trimmed_mean();
            interior_results++;
        end
        else
        begin
            beat.px = win[1][1];
        end
        beat.frame_end = (orow >= h - 1) && (ocol == w - 1);
        if (beat.frame_end)
        begin
            next_row = 0;
            next_col = 0;
            frames_done++;
        end
        filtered_q.push_back(beat);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        out_beat_t got;
        out_beat_t want;
        logic      bad;
        int        i;
        int        r;
        int        c;
        if (!rst_n)
        begin
            cfg_width = FRAME_WIDTH_RESET;
            cfg_height = FRAME_HEIGHT_RESET;
            for (i = 0; i < MAX_WIDTH; i++)
            begin
                upper_row[i] = '0;
                lower_row[i] = '0;
            end
            for (r = 0; r < 3; r++)
            begin
                for (c = 0; c < 3; c++)
                begin
                    win[r][c] = '0;
                end
            end
            next_col = 0;
            next_row = 0;
            filtered_q.delete();
            mismatches = 0;
            frames_done = 0;
            results_checked = 0;
            interior_results = 0;
            flushes_dropped = 0;
        end
        else
        begin
            // track register writes
            if (cfg_write)
            begin
                if (cfg_index == REG_FRAME_WIDTH)
                    cfg_width = cfg_data[FW_W-1:0];
                else if (cfg_index == REG_FRAME_HEIGHT)
                    cfg_height = cfg_data[FH_W-1:0];
            end

            // predict from every accepted input beat
            if (pixel_in.valid && pixel_in.ready)
                predict_filtered(pixel_in.op,
                                 {pixel_in.in_red, pixel_in.in_green, pixel_in.in_blue});

            // compare every accepted output beat with the oldest expectation
            if (pixel_out.valid && pixel_out.ready)
            begin
                got.px = {pixel_out.out_red, pixel_out.out_green, pixel_out.out_blue};
                got.frame_end = pixel_out.frame_end;
                results_checked++;
                if (filtered_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: pixel_out beat with none expected: %s",
                             $time, "expected nothing");
                    $display("%0t:   got r=%02h g=%02h b=%02h end=%0b",
                             $time, got.px[2], got.px[1], got.px[0], got.frame_end);
                end
                else
                begin
                    want = filtered_q.pop_front();
                    bad = (got.px[2] !== want.px[2]) || (got.px[1] !== want.px[1]) ||
                          (got.px[0] !== want.px[0]) || (got.frame_end !== want.frame_end);
                    if (bad)
                    begin
                        mismatches++;
                        $display("%0t: pixel_out mismatch: expected r=%02h g=%02h b=%02h end=%0b",
                                 $time, want.px[2], want.px[1], want.px[0], want.frame_end);
                        $display("%0t:   got r=%02h g=%02h b=%02h end=%0b",
                                 $time, got.px[2], got.px[1], got.px[0], got.frame_end);
                    end
                end
            end
        end
        pending = filtered_q.size();
    end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stream bench of the trimmed-mean 3x3 RGB filter
// Drives raster frames of many sizes through pixel_in with random gaps,
// stalls pixel_out at random and once for a long stretch, and writes the
// frame size registers between frames. The checker beside the block
// predicts and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------

module tb_top;
    import refb_pkg::*;
    import refb_tb_pkg::*;

    localparam int CYCLE_LIMIT     = 400_000;
    localparam int RANDOM_BEATS    = 850;
    localparam int RESET_CYCLES    = 12;
    localparam int SETTLE_CYCLES   = 12;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PRESSURE_WIDTH  = 40;
    localparam int CUT_WIDTH       = 4;
    localparam int CUT_ROWS        = 7;
    localparam int CUT_HEIGHT      = 5;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    refb_pixel_in_if  pix_in ();
    refb_pixel_out_if pix_out ();

    int     mismatches;
    int     pending;
    int     frames_done;
    int     results_checked;
    int     interior_results;
    int     flushes_dropped;
    int     cycle_count = 0;
    int     stream_beats = 0;
    bit     no_idle = 1'b0;
    bit     hold_off_req = 1'b0;
    pixel_t last_px = '0;

    rgb_extremum_filtered_blur_3x3 i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel_in  (pix_in),
        .pixel_out (pix_out)
    );

    refb_filter_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .pixel_in         (pix_in),
        .pixel_out        (pix_out),
        .mismatches       (mismatches),
        .pending          (pending),
        .frames_done      (frames_done),
        .results_checked  (results_checked),
        .interior_results (interior_results),
        .flushes_dropped  (flushes_dropped)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycle_count, pending);
            $display("[rgb_extremum_filtered_blur_3x3] ERROR");
            $finish;
        end
    end

    // Offer one beat after a random gap and hold it until accepted
    task automatic push_beat(input beat_op_t op, input pixel_t px);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_in.valid    <= 1'b1;
        pix_in.op       <= op;
        pix_in.in_red   <= px[2];
        pix_in.in_green <= px[1];
        pix_in.in_blue  <= px[0];
        do @(posedge clk); while (!pix_in.ready);
        @(negedge clk);
    endtask

    // Mostly uniform pixels, some saturated, some with the same channel sum
    function automatic pixel_t random_pixel(pixel_t prev);
        pixel_t px;
        int     k;
        case ($urandom_range(0, 9))
            0: px = prev;
            1: px = {prev[0], prev[2], prev[1]};
            2, 3:
            begin
                for (k = 0; k < 3; k++)
                begin
                    px[k] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end
            end
            default: px = pixel_t'($urandom);
        endcase
        return px;
    endfunction

    // Send pixel beats, with an occasional flush that the open frame ignores
    task automatic send_pixels(input int count);
        pixel_t px;
        int     n;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 15) == 0)
                push_beat(BEAT_FLUSH, pixel_t'($urandom));
            px = random_pixel(last_px);
            last_px = px;
            push_beat(BEAT_PIXEL, px);
            stream_beats++;
        end
    endtask

    task automatic send_listed(input pixel_t frame_px [9]);
        int n;
        for (n = 0; n < 9; n++)
        begin
            if (n == 4)
                push_beat(BEAT_FLUSH, '1);
            push_beat(BEAT_PIXEL, frame_px[n]);
            stream_beats++;
        end
    endtask

    // Drain the tail with flush or dropped pixel beats until the frame closes
    task automatic drain_frame();
        int target;
        target = frames_done + 1;
        while (frames_done < target)
        begin
            push_beat(beat_op_t'($urandom_range(0, 1)), pixel_t'($urandom));
            stream_beats++;
        end
    endtask

    // Stop offering, wait for every expected beat, then let the pipe empty
    task automatic settle();
        pix_in.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // Output side: random stalls, one long hold-off on request
    initial
    begin : result_sink
        int gap;
        pix_out.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 3);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                gap = HOLD_OFF_CYCLES;
            end
            if (gap > 0)
            begin
                pix_out.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pix_out.ready <= 1'b1;
            do @(posedge clk); while (!pix_out.valid);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        pixel_t                tie_px [9];
        pixel_t                extreme_px [9];
        int                    w_eff;
        int                    h_eff;
        int                    goal;
        logic [CFG_DATA_W-1:0] w_code;
        logic [CFG_DATA_W-1:0] h_code;

        cfg_write       = 1'b0;
        cfg_index       = REG_FRAME_WIDTH;
        cfg_data        = '0;
        pix_in.valid    = 1'b0;
        pix_in.op       = BEAT_PIXEL;
        pix_in.in_red   = '0;
        pix_in.in_green = '0;
        pix_in.in_blue  = '0;

        // every pixel has the same channel sum: first is brightest, last darkest
        tie_px = '{24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h555555, 24'h807F00,
                   24'h01FE00, 24'h0001FE, 24'hFE0001, 24'h7F0080};
        extreme_px = '{24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
                       24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF};

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // smallest frames with hand-picked content
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(MIN_DIM));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(MIN_DIM));
        send_listed(tie_px);
        drain_frame();
        send_listed(extreme_px);
        drain_frame();

        // random small frames, registers rewritten before each
        goal = stream_beats + RANDOM_BEATS;
        while (stream_beats < goal)
        begin
            settle();
            w_eff = ($urandom_range(0, 5) == 0) ? MIN_DIM : $urandom_range(3, 8);
            h_eff = $urandom_range(3, 6);
            case ($urandom_range(0, 7))
                0:
                begin
                    w_code = CFG_DATA_W'($urandom_range(0, 2));
                    w_eff = MIN_DIM;
                end
                1: w_code = 16'hF800 | CFG_DATA_W'(w_eff);
                default: w_code = CFG_DATA_W'(w_eff);
            endcase
            if ($urandom_range(0, 7) == 0)
            begin
                h_code = CFG_DATA_W'($urandom_range(0, 2));
                h_eff = MIN_DIM;
            end
            else
            begin
                h_code = CFG_DATA_W'(h_eff);
            end
            write_reg(REG_FRAME_WIDTH, w_code);
            write_reg(REG_FRAME_HEIGHT, h_code);
            no_idle = ($urandom_range(0, 3) == 0);
            send_pixels(w_eff * h_eff);
            drain_frame();
        end

        // wider frame (height under the floor), output held off for a long stretch
        settle();
        no_idle = 1'b1;
        write_reg(REG_FRAME_WIDTH, 16'hF800 | CFG_DATA_W'(PRESSURE_WIDTH));
        write_reg(REG_FRAME_HEIGHT, 16'd1);
        hold_off_req = 1'b1;
        send_pixels(PRESSURE_WIDTH * MIN_DIM);
        drain_frame();

        // tallest frame, closed early by lowering the height below the open row
        settle();
        no_idle = 1'b0;
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(CUT_WIDTH));
        write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
        send_pixels(CUT_WIDTH * CUT_ROWS);
        settle();
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(CUT_HEIGHT));
        drain_frame();

        settle();
        $display("Ran %0d frames in %0d cycles: %0d output beats checked, %0d filtered",
                 frames_done, cycle_count, results_checked, interior_results);
        $display("Widths 3..40 with low and masked codes, heights 3..65535, %0d flushes ignored",
                 flushes_dropped);
        if (mismatches == 0 && pending == 0)
            $display("[rgb_extremum_filtered_blur_3x3] OK");
        else
            $display("[rgb_extremum_filtered_blur_3x3] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/refb_pkg.sv
rtl/core/refb_stream_ifs.sv
rtl/core/refb_ctrl.sv
rtl/core/refb_line_mem.sv
rtl/core/refb_window.sv
rtl/core/refb_out_fifo.sv
rtl/core/rgb_extremum_filtered_blur_3x3.sv
dv/refb_tb_pkg.sv
dv/refb_filter_checker.sv
dv/tb_top.sv
